// ===== hdl/tld_pkg.sv =====
// Shared types and constants for the takeoff and landing detector.
// Depends on nothing; used by every module under hdl.
`default_nettype none

package tld_pkg;

    // Flight mode codes
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_FLIGHT = 2'd1;
    localparam logic [1:0] MODE_LAND   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ALWAYS  = 2'd0;
    localparam logic [1:0] REG_START   = 2'd1;
    localparam logic [1:0] REG_LAND    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // Statistic start values after reset
    localparam logic signed [15:0] STAT_MAX_RESET = -16'sd32678;
    localparam logic signed [15:0] STAT_MIN_RESET = 16'sd32677;

    // Milliseconds per second; timeout held in ms needs 18 bits (255 * 1000)
    localparam int unsigned MS_PER_S = 1000;
    localparam int unsigned TMO_W    = 18;

    // Bus widths
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration as seen by the core
    typedef struct packed {
        logic             always_en;
        logic [7:0]       start_sens;
        logic [7:0]       land_sens;
        logic [TMO_W-1:0] tmo_ms;
    } t_cfg;

    // One input item
    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] altitude_m;
        logic               baro_ok;
        logic signed [15:0] vario_cms;
    } t_item;

    // Handshake between input stage and core
    typedef struct packed {
        logic take;
    } t_link;

endpackage

`default_nettype wire

// ===== hdl/takeoff_landing_detector.sv =====
// Top level of the takeoff and landing detector.
// Depends on tld_pkg, tld_cfg, tld_in_stage and tld_core.
//
//  Port group   Direction  Fields
//  s (tick)     in         tdata: now_ms, altitude_m, vario_cms; tuser: baro_ok
//  m (status)   out        tdata: mode, took_off, landed, duration_ms, highest_alt,
//                                 lowest_alt, best_climb, worst_sink
//  cfg          in         write enable, register index, 8-bit data
//
// One item per cycle while the result side is not stalled; an accepted item passes
// through the input register, then the state update into the result register.
// Reset is synchronous, active low; it clears mode, references and valid flags and
// sets the statistics to their start values. A stalled result holds the result
// register; the input register takes one more item and holds until the result drains.
`default_nettype none

module takeoff_landing_detector (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tick: now_ms[31:0], altitude_m[47:32], vario_cms[63:48]
    input  wire logic [tld_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tick: baro_ok[0]
    input  wire logic                            i_s_tuser,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // status: mode[1:0], took_off[2], landed[3], duration_ms[35:4],
    // highest_alt[51:36], lowest_alt[67:52], best_climb[83:68],
    // worst_sink[99:84], zero pad[103:100]
    output logic [tld_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_idx,
    input  wire logic [tld_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tld_pkg::t_cfg  w_cfg;
    tld_pkg::t_item w_item;
    tld_pkg::t_link w_link;
    logic           w_in_valid;

    tld_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tld_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (w_link.take),
        .o_valid    (w_in_valid),
        .o_item     (w_item)
    );

    tld_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_in_valid),
        .i_item     (w_item),
        .o_link     (w_link),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/tld_cfg.sv =====
// Configuration registers of the takeoff and landing detector.
// Depends on tld_pkg; the timeout is converted to ms at write time.
`default_nettype none

module tld_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_idx,
    input  wire logic [tld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tld_pkg::t_cfg                       o_cfg
);

    tld_pkg::t_cfg r_cfg;
    logic [tld_pkg::TMO_W-1:0] n_tmo_ms;

    // Scale seconds to milliseconds once, on the write
    assign n_tmo_ms = tld_pkg::TMO_W'({10'd0, i_cfg_data}
                                      * tld_pkg::TMO_W'(tld_pkg::MS_PER_S));

    // Hold registers, update on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tld_pkg::REG_ALWAYS:  r_cfg.always_en  <= i_cfg_data[0];
                tld_pkg::REG_START:   r_cfg.start_sens <= i_cfg_data;
                tld_pkg::REG_LAND:    r_cfg.land_sens  <= i_cfg_data;
                tld_pkg::REG_TIMEOUT: r_cfg.tmo_ms     <= n_tmo_ms;
                default:              r_cfg            <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/tld_in_stage.sv =====
// Input register stage of the takeoff and landing detector.
// Depends on tld_pkg; holds one item until the core takes it.
`default_nettype none

module tld_in_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [tld_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                          i_s_tuser,
    input  wire logic                          i_take,
    output logic                               o_valid,
    output tld_pkg::t_item                     o_item
);

    logic           r_valid;
    tld_pkg::t_item r_item;
    logic           w_accept;

    // Free when empty or when the held item moves on this cycle
    assign o_s_tready = !r_valid || i_take;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_take);
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.now_ms     <= i_s_tdata[31:0];
            r_item.altitude_m <= i_s_tdata[47:32];
            r_item.vario_cms  <= i_s_tdata[63:48];
            r_item.baro_ok    <= i_s_tuser;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/tld_core.sv =====
// Flight state update and result register of the takeoff and landing detector.
// Depends on tld_pkg; consumes one held item per cycle when the result slot frees.
`default_nettype none

module tld_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tld_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_valid,
    input  wire tld_pkg::t_item                  i_item,
    output tld_pkg::t_link                       o_link,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [tld_pkg::OUT_DATA_W-1:0]       o_m_tdata
);

    // Flight state
    logic [1:0]         r_mode;
    logic signed [15:0] r_ref_alt;
    logic [31:0]        r_ref_time;
    logic [31:0]        r_flight_time;
    logic signed [15:0] r_max_alt;
    logic signed [15:0] r_min_alt;
    logic signed [15:0] r_climb;
    logic signed [15:0] r_sink;

    logic [1:0]         n_mode;
    logic signed [15:0] n_ref_alt;
    logic [31:0]        n_ref_time;
    logic [31:0]        n_flight_time;
    logic signed [15:0] n_max_alt;
    logic signed [15:0] n_min_alt;
    logic signed [15:0] n_climb;
    logic signed [15:0] n_sink;
    logic               n_took;
    logic               n_landed;

    // Result register
    logic                          r_out_valid;
    logic [tld_pkg::OUT_DATA_W-1:0] r_out_data;

    logic               w_take;
    logic signed [16:0] w_diff;
    logic [16:0]        w_dist;
    logic [31:0]        w_tmo;
    logic [31:0]        w_elapsed;
    logic               w_timed_out;
    logic               w_out_start;
    logic               w_in_land;

    // Move an item whenever the result slot is empty or being drained
    assign w_take        = i_valid && (!r_out_valid || i_m_tready);
    assign o_link.take   = w_take;

    // Distance to reference and time since reference
    assign w_diff      = 17'(i_item.altitude_m) - 17'(r_ref_alt);
    assign w_dist      = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_tmo       = {{(32 - tld_pkg::TMO_W){1'b0}}, i_cfg.tmo_ms};
    assign w_elapsed   = i_item.now_ms - r_ref_time;
    assign w_timed_out = w_elapsed > w_tmo;
    assign w_out_start = w_dist > {9'd0, i_cfg.start_sens};
    assign w_in_land   = w_dist < {9'd0, i_cfg.land_sens};

    // Next flight state for the held item
    always_comb begin
        n_mode        = r_mode;
        n_ref_alt     = r_ref_alt;
        n_ref_time    = r_ref_time;
        n_flight_time = r_flight_time;
        n_took        = 1'b0;
        n_landed      = 1'b0;

        if (i_cfg.always_en) begin
            if (i_item.baro_ok && r_mode == tld_pkg::MODE_WAIT) begin
                n_mode        = tld_pkg::MODE_FLIGHT;
                n_flight_time = i_item.now_ms;
                n_ref_alt     = i_item.altitude_m;
                n_ref_time    = i_item.now_ms;
                n_took        = 1'b1;
            end
        end else if (r_mode == tld_pkg::MODE_FLIGHT) begin
            // Landing check; a takeoff on this tick cannot land
            if (i_cfg.land_sens != 8'd0) begin
                if (w_in_land) begin
                    if (w_timed_out) begin
                        n_flight_time = i_item.now_ms - (r_flight_time + w_tmo);
                        n_mode        = tld_pkg::MODE_LAND;
                        n_ref_time    = i_item.now_ms;
                        n_landed      = 1'b1;
                    end
                end else begin
                    n_ref_alt  = i_item.altitude_m;
                    n_ref_time = i_item.now_ms;
                end
            end
        end else if (i_item.baro_ok && i_cfg.start_sens != 8'd0
                     && (r_mode == tld_pkg::MODE_WAIT
                         || r_mode == tld_pkg::MODE_LAND)) begin
            // Band takeoff, else refresh the reference after the timeout
            if (w_out_start) begin
                n_mode        = tld_pkg::MODE_FLIGHT;
                n_flight_time = i_item.now_ms;
                n_ref_alt     = i_item.altitude_m;
                n_ref_time    = i_item.now_ms;
                n_took        = 1'b1;
            end else if (w_timed_out) begin
                n_ref_time = i_item.now_ms;
                n_ref_alt  = i_item.altitude_m;
            end
        end
    end

    // Statistics follow the mode after this tick's update
    always_comb begin
        n_max_alt = r_max_alt;
        n_min_alt = r_min_alt;
        n_climb   = r_climb;
        n_sink    = r_sink;
        if (n_mode == tld_pkg::MODE_FLIGHT) begin
            if (i_item.altitude_m > r_max_alt) n_max_alt = i_item.altitude_m;
            if (i_item.altitude_m < r_min_alt) n_min_alt = i_item.altitude_m;
            if (i_item.vario_cms > r_climb)    n_climb   = i_item.vario_cms;
            if (i_item.vario_cms < r_sink)     n_sink    = i_item.vario_cms;
        end
    end

    // Hold state, advance on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= tld_pkg::MODE_WAIT;
            r_ref_alt     <= '0;
            r_ref_time    <= '0;
            r_flight_time <= '0;
            r_max_alt     <= tld_pkg::STAT_MAX_RESET;
            r_min_alt     <= tld_pkg::STAT_MIN_RESET;
            r_climb       <= '0;
            r_sink        <= '0;
        end else if (w_take) begin
            r_mode        <= n_mode;
            r_ref_alt     <= n_ref_alt;
            r_ref_time    <= n_ref_time;
            r_flight_time <= n_flight_time;
            r_max_alt     <= n_max_alt;
            r_min_alt     <= n_min_alt;
            r_climb       <= n_climb;
            r_sink        <= n_sink;
        end
    end

    // Result slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_take || (r_out_valid && !i_m_tready);
        end
    end

    // Pack the result item, lowest field first
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= {4'd0, n_sink, n_climb, n_min_alt, n_max_alt,
                           n_flight_time, n_landed, n_took, n_mode};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== bench/tld_checker.sv =====
// Scoreboard for the takeoff and landing detector: predicts one status item
// per tick and compares it with what the block sends out.
// Depends on tld_pkg for mode codes, register indexes and bus widths.
module tld_checker
    import tld_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_takeoffs,
    output int                         o_landings
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]         pad;
        logic [1:0]         mode;
        logic               took_off;
        logic               landed;
        logic [31:0]        duration_ms;
        logic signed [15:0] highest_alt;
        logic signed [15:0] lowest_alt;
        logic signed [15:0] best_climb;
        logic signed [15:0] worst_sink;
    } status_t;

    // Register copies
    logic        cfg_always;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_land;
    logic [7:0]  cfg_tmo_s;

    // Flight state copy
    logic [1:0]         fl_mode;
    logic signed [15:0] ref_alt;
    logic [31:0]        ref_ms;
    logic [31:0]        start_ms;
    logic signed [15:0] alt_hi;
    logic signed [15:0] alt_lo;
    logic signed [15:0] climb_hi;
    logic signed [15:0] sink_lo;

    status_t status_due[$];
    int      fails;
    int      results_seen;
    int      takeoffs;
    int      landings;

    function automatic int alt_gap(logic signed [15:0] a, logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic void launch(logic [31:0] now, logic signed [15:0] alt);
        fl_mode  = MODE_FLIGHT;
        start_ms = now;
        ref_alt  = alt;
        ref_ms   = now;
    endfunction

    // Advance the flight state by one tick and return the status it produces
    function automatic status_t predict_status(logic [31:0] now, logic signed [15:0] alt,
                                               logic baro, logic signed [15:0] vario);
        logic [31:0] tmo;
        status_t     st;
        tmo = 32'(cfg_tmo_s) * 32'd1000;
        st  = '0;
        if (cfg_always) begin
            if (baro && fl_mode == MODE_WAIT) begin
                launch(now, alt);
                st.took_off = 1'b1;
            end
        end else begin
            // band takeoff from waiting or landed, else refresh the reference
            if (baro && (fl_mode == MODE_WAIT || fl_mode == MODE_LAND) && cfg_start != 0) begin
                if (alt_gap(alt, ref_alt) > int'(cfg_start)) begin
                    launch(now, alt);
                    st.took_off = 1'b1;
                end else if (now - ref_ms > tmo) begin
                    ref_ms  = now;
                    ref_alt = alt;
                end
            end
            // landing: stay inside the band past the timeout
            if (fl_mode == MODE_FLIGHT && cfg_land != 0) begin
                if (alt_gap(alt, ref_alt) < int'(cfg_land)) begin
                    if (now - ref_ms > tmo) begin
                        start_ms  = now - (start_ms + tmo);
                        fl_mode   = MODE_LAND;
                        ref_ms    = now;
                        st.landed = 1'b1;
                    end
                end else begin
                    ref_alt = alt;
                    ref_ms  = now;
                end
            end
        end
        // flight statistics
        if (fl_mode == MODE_FLIGHT) begin
            if (alt > alt_hi) alt_hi = alt;
            if (alt < alt_lo) alt_lo = alt;
            if (vario > climb_hi) climb_hi = vario;
            if (vario < sink_lo) sink_lo = vario;
        end
        st.mode        = fl_mode;
        st.duration_ms = start_ms;
        st.highest_alt = alt_hi;
        st.lowest_alt  = alt_lo;
        st.best_climb  = climb_hi;
        st.worst_sink  = sink_lo;
        return st;
    endfunction

    always @(posedge i_clk) begin
        status_t got;
        status_t want;
        if (!i_rst_n) begin
            cfg_always = 1'b0;
            cfg_start  = '0;
            cfg_land   = '0;
            cfg_tmo_s  = '0;
            fl_mode    = MODE_WAIT;
            ref_alt    = '0;
            ref_ms     = '0;
            start_ms   = '0;
            alt_hi     = STAT_MAX_RESET;
            alt_lo     = STAT_MIN_RESET;
            climb_hi   = '0;
            sink_lo    = '0;
            status_due.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALWAYS:  cfg_always = i_cfg_data[0];
                    REG_START:   cfg_start  = i_cfg_data;
                    REG_LAND:    cfg_land   = i_cfg_data;
                    REG_TIMEOUT: cfg_tmo_s  = i_cfg_data;
                    default: ;
                endcase
            end
            // compare the outgoing status with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                got.pad         = i_m_tdata[103:100];
                got.mode        = i_m_tdata[1:0];
                got.took_off    = i_m_tdata[2];
                got.landed      = i_m_tdata[3];
                got.duration_ms = i_m_tdata[35:4];
                got.highest_alt = i_m_tdata[51:36];
                got.lowest_alt  = i_m_tdata[67:52];
                got.best_climb  = i_m_tdata[83:68];
                got.worst_sink  = i_m_tdata[99:84];
                if (status_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("status %0d arrived with no tick pending", results_seen);
                end else begin
                    want = status_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("status %0d mismatch", results_seen);
                            $display("  want mode=%0d to=%0b ld=%0b dur=%0d hi=%0d lo=%0d clb=%0d snk=%0d pad=%h",
                                     want.mode, want.took_off, want.landed, want.duration_ms,
                                     want.highest_alt, want.lowest_alt, want.best_climb,
                                     want.worst_sink, want.pad);
                            $display("  got  mode=%0d to=%0b ld=%0b dur=%0d hi=%0d lo=%0d clb=%0d snk=%0d pad=%h",
                                     got.mode, got.took_off, got.landed, got.duration_ms,
                                     got.highest_alt, got.lowest_alt, got.best_climb,
                                     got.worst_sink, got.pad);
                        end
                    end
                end
            end
            // predict for each accepted tick
            if (i_s_tvalid && i_s_tready) begin
                want = predict_status(i_s_tdata[31:0], i_s_tdata[47:32], i_s_tuser,
                                      i_s_tdata[63:48]);
                if (want.took_off) takeoffs++;
                if (want.landed) landings++;
                status_due.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= status_due.size();
        o_takeoffs   <= takeoffs;
        o_landings   <= landings;
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the takeoff and landing detector: clock, reset, tick and
// register stimulus, and the verdict. Depends on tld_pkg, tld_checker and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tld_pkg::*;

    localparam int TICK_TARGET = 1450;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_idx   = REG_ALWAYS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int takeoffs;
    int landings;

    int          sent      = 0;
    int          settings  = 0;
    int          rdy_hold  = 0;
    bit          bursts_on = 1'b0;
    logic [31:0] now_ms    = '0;
    int          cur_start = 0;
    int          cur_land  = 0;
    int          cur_tmo   = 0;

    takeoff_landing_detector dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tld_checker watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_takeoffs   (takeoffs),
        .o_landings   (landings)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the status side in bursts of random length
    always @(posedge clk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rdy_hold <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Hard stop on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one tick item and hold it until taken; clamp altitude to 16 bits
    task automatic push_tick(input logic [31:0] t_ms, input int alt, input logic baro,
                             input logic [15:0] vario);
        int          a;
        logic [15:0] alt16;
        a     = (alt > 32767) ? 32767 : ((alt < -32768) ? -32768 : alt);
        alt16 = a[15:0];
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vario, alt16, t_ms};
        s_tuser  <= baro;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    // Drain: hold the sender until every status has come back
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic set_config(input logic ae, input int ss, input int ls, input int tmo_s);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_ALWAYS;
        cfg_data <= {7'd0, ae};
        @(posedge clk);
        cfg_idx  <= REG_START;
        cfg_data <= 8'(ss);
        @(posedge clk);
        cfg_idx  <= REG_LAND;
        cfg_data <= 8'(ls);
        @(posedge clk);
        cfg_idx  <= REG_TIMEOUT;
        cfg_data <= 8'(tmo_s);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_start = ss;
        cur_land  = ls;
        cur_tmo   = tmo_s * 1000;
        settings++;
    endtask

    // Time step scaled to the timeout so landings happen within a few ticks
    function automatic logic [31:0] tick_step();
        if (cur_tmo == 0)
            return $urandom_range(1, 1500);
        return $urandom_range(cur_tmo / 4 + 1, cur_tmo / 2 + 1500);
    endfunction

    function automatic logic [15:0] pick_vario();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 65535);
        return 16'(int'($urandom_range(0, 800)) - 400);
    endfunction

    function automatic logic pick_baro();
        return $urandom_range(0, 11) != 0;
    endfunction

    function automatic int pick_sens(input int top);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 255;
            default: return $urandom_range(2, top);
        endcase
    endfunction

    // One flight: hover on the ground, leave the start band, cruise, settle
    task automatic fly_profile();
        int base;
        int hop;
        int lvl;
        base = int'($urandom_range(0, 40000)) - 20000;
        repeat ($urandom_range(2, 6)) begin
            now_ms += tick_step();
            push_tick(now_ms, base + int'($urandom_range(0, cur_start / 2)), pick_baro(),
                      pick_vario());
        end
        hop = cur_start + 1 + int'($urandom_range(0, 30));
        if ($urandom_range(0, 1) == 1) hop = -hop;
        lvl = base + hop;
        now_ms += tick_step();
        push_tick(now_ms, lvl, 1'b1, pick_vario());
        repeat ($urandom_range(3, 12)) begin
            lvl += int'($urandom_range(0, 2 * (cur_land + 20))) - (cur_land + 20);
            now_ms += tick_step();
            push_tick(now_ms, lvl, pick_baro(), pick_vario());
        end
        repeat ($urandom_range(3, 7)) begin
            now_ms += tick_step();
            push_tick(now_ms, lvl + int'($urandom_range(0, (cur_land > 0) ? cur_land - 1 : 0)),
                      pick_baro(), pick_vario());
        end
    endtask

    // Fully random tick, sometimes jumping the clock anywhere
    task automatic push_noise();
        if ($urandom_range(0, 2) == 0) now_ms = $urandom();
        push_tick($urandom_range(0, 2) == 0 ? now_ms : $urandom(),
                  int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 1) == 1,
                  $urandom_range(0, 65535));
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset: nothing may take off
        push_tick(32'd0, -32768, 1'b1, 16'h7FFF);
        push_tick(32'hFFFF_FFFF, 32767, 1'b1, 16'h8000);

        // Always-on: blocked without barometer, then immediate takeoff and extremes
        wait_quiet();
        set_config(1'b1, 0, 0, 0);
        push_tick(32'd1000, 100, 1'b0, 16'd0);
        push_tick(32'd2000, 100, 1'b1, 16'd50);
        push_tick(32'd3000, 32767, 1'b1, 16'h7FFF);
        push_tick(32'd4000, -32768, 1'b1, 16'h8000);

        // Band mode: landing, blocked barometer, takeoff from landed,
        // backwards clock with duration wrap, reference refresh, band edges
        wait_quiet();
        set_config(1'b0, 10, 5, 1);
        push_tick(32'd5000, 0, 1'b1, 16'd0);
        push_tick(32'd5500, 2, 1'b1, 16'd0);
        push_tick(32'd6200, 3, 1'b1, 16'd0);
        push_tick(32'd6300, 50, 1'b0, 16'd0);
        push_tick(32'd6400, 50, 1'b1, 16'd10);
        push_tick(32'd6500, 52, 1'b1, 16'd20);
        push_tick(32'd100, 51, 1'b1, 16'd0);
        push_tick(32'd200, 52, 1'b1, 16'd0);
        push_tick(32'd1500, 53, 1'b1, 16'd0);
        push_tick(32'd1600, 63, 1'b1, 16'd0);
        push_tick(32'd1700, 64, 1'b1, 16'd0);
        push_tick(32'd1800, 69, 1'b1, 16'd0);
        push_tick(32'd1900, 70, 1'b1, 16'd0);
        push_tick(32'd3000, 71, 1'b1, 16'd0);
        now_ms = 32'd3000;

        // Random flights under changing settings; quiet at the end
        while (sent < TICK_TARGET) begin
            wait_quiet();
            bursts_on = (sent < TICK_TARGET - 200) && ($urandom_range(0, 3) != 0);
            case (settings)
                3:       set_config(1'b0, 1, 1, 0);
                4:       set_config(1'b0, 255, 255, 255);
                default: set_config($urandom_range(0, 5) == 0, pick_sens(40), pick_sens(30),
                                    ($urandom_range(0, 7) == 0) ? 255 :
                                    (($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 5)));
            endcase
            repeat ($urandom_range(1, 3)) begin
                fly_profile();
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 4)) push_noise();
            end
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        $display("Drove %0d ticks under %0d register settings; %0d takeoffs, %0d landings.",
                 sent, settings, takeoffs, landings);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
